@@ rtl/core/murmur_quadratic_probe_hash_table_unit_defines.svh @@
// Assertion macros for the hash table unit.
`ifndef MURMUR_QUADRATIC_PROBE_HASH_TABLE_UNIT_DEFINES_SVH
`define MURMUR_QUADRATIC_PROBE_HASH_TABLE_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define MQP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define MQP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/mqp_pkg.sv @@
// ----------------------------------------------------------------------------
// mqp_pkg
// Types and constants shared by the hash table unit.
// ----------------------------------------------------------------------------
package mqp_pkg;

  localparam int unsigned DefaultDepth = 1024;
  localparam logic [63:0] HashSeed = 64'h0000_0000_c70f_6907;
  localparam logic [63:0] HashMul = 64'hc6a4_a793_5bd1_e995;
  localparam int unsigned HashShift = 47;
  localparam logic [63:0] KeyBytes = 64'd16;
  localparam logic [10:0] LimitReset = 11'd512;
  localparam logic [10:0] CountMax = 11'd2047;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_FULL      = 3'd5,
    ST_NULL_KEY  = 3'd6
  } status_t;

  localparam logic [1:0] KindSet = 2'd0;
  localparam logic [1:0] KindGet = 2'd1;
  localparam logic [1:0] KindRemove = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_value;
    logic [9:0]  slot_index;
  } rsp_t;

  // control between sequencer and hash unit
  typedef struct packed {
    logic        start;
    logic [63:0] key_low;
    logic [63:0] key_high;
  } hash_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] hash;
  } hash_rsp_t;

endpackage

@@ rtl/core/murmur_quadratic_probe_hash_table_unit.sv @@
// ----------------------------------------------------------------------------
// murmur_quadratic_probe_hash_table_unit
// Open-addressing hash table, 128-bit keys, probing with squared steps.
//
//   channel  signals                   dir
//   req      req_valid/req_ready/req   in
//   rsp      rsp_valid/rsp_ready/rsp   out
//   cfg      cfg_we/cfg_data           in
//
// The hash runs seven multiplies on one 32x32 multiplier, then hands the
// hash over; each probe is a key/value RAM read, then a compare. Null keys,
// undefined kinds and full refusals are answered in the cycle after they
// are accepted, without hashing. After reset a clearing pass over all
// TABLE_DEPTH slots empties the key store; no item is taken meanwhile.
// A stalled result holds the block busy.
// ----------------------------------------------------------------------------
`include "murmur_quadratic_probe_hash_table_unit_defines.svh"

module murmur_quadratic_probe_hash_table_unit
  import mqp_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefaultDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic [10:0] cfg_data
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_READ, S_CHECK, S_RESP
  } state_t;

  state_t      state;
  req_t        cur;
  logic [10:0] load_limit;
  logic [10:0] entry_count;
  logic [AW-1:0] slot;
  logic [AW:0]   step;
  logic [AW-1:0] clr_addr;

  logic [63:0] klo_mem [TABLE_DEPTH];
  logic [63:0] khi_mem [TABLE_DEPTH];
  logic [31:0] val_mem [TABLE_DEPTH];
  logic [63:0] rd_lo, rd_hi;
  logic [31:0] rd_val;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_lo, wr_hi;
  logic          vwr_en;
  logic [31:0]   vwr_data;

  hash_req_t hreq;
  hash_rsp_t hrsp;

  mqp_hash u_hash (.clk(clk), .rst(rst), .req(hreq), .rsp(hrsp));

  assign hreq.start = (state == S_IDLE) && req_valid &&
                      (req.key_low != 64'd0 || req.key_high != 64'd0) &&
                      (req.kind == KindGet || req.kind == KindRemove ||
                       (req.kind == KindSet && entry_count <= load_limit));
  assign hreq.key_low = req.key_low;
  assign hreq.key_high = req.key_high;
  assign req_ready = (state == S_IDLE);

  logic is_empty, is_match, last_probe;
  assign is_empty = (rd_lo == 64'd0) && (rd_hi == 64'd0);
  assign is_match = (rd_lo == cur.key_low) && (rd_hi == cur.key_high);
  assign last_probe = (step == (AW+1)'(TABLE_DEPTH - 1));

  logic [AW-1:0] step_sq;
  logic [2*AW+1:0] sq_full;
  assign sq_full = (step + 1'b1) * (step + 1'b1);
  assign step_sq = sq_full[AW-1:0];

  always_comb begin
    wr_en = 1'b0;
    vwr_en = 1'b0;
    wr_addr = slot;
    wr_lo = cur.key_low;
    wr_hi = cur.key_high;
    vwr_data = cur.value;
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
      wr_addr = clr_addr;
      wr_lo = 64'd0;
      wr_hi = 64'd0;
    end else if (state == S_CHECK) begin
      if (cur.kind == KindSet) begin
        wr_en = is_empty;
        vwr_en = is_empty || is_match;
      end else if (cur.kind == KindRemove && !is_empty && is_match) begin
        wr_en = 1'b1;
        wr_lo = 64'd0;
        wr_hi = 64'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      klo_mem[wr_addr] <= wr_lo;
      khi_mem[wr_addr] <= wr_hi;
    end
    if (vwr_en) val_mem[wr_addr] <= vwr_data;
    rd_lo <= klo_mem[slot];
    rd_hi <= khi_mem[slot];
    rd_val <= val_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      entry_count <= 11'd0;
      load_limit <= LimitReset;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) load_limit <= cfg_data;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(TABLE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            cur <= req;
            step <= '0;
            rsp.found_value <= 32'd0;
            rsp.slot_index <= 10'd0;
            if (req.key_low == 64'd0 && req.key_high == 64'd0) begin
              rsp.status <= ST_NULL_KEY;
              rsp_valid <= 1'b1;
              state <= S_RESP;
            end else if (hreq.start) begin
              state <= S_HASH;
            end else begin
              rsp.status <= (req.kind == KindSet) ? ST_FULL : ST_NOT_FOUND;
              rsp_valid <= 1'b1;
              state <= S_RESP;
            end
          end
        end
        S_HASH: begin
          if (hrsp.done) begin
            slot <= hrsp.hash[AW-1:0];
            state <= S_READ;
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          rsp.slot_index <= 10'(slot);
          if (cur.kind == KindSet && is_empty) begin
            rsp.status <= ST_INSERTED;
            if (entry_count != CountMax) entry_count <= entry_count + 11'd1;
            rsp_valid <= 1'b1;
            state <= S_RESP;
          end else if (cur.kind == KindSet && is_match) begin
            rsp.status <= ST_UPDATED;
            rsp_valid <= 1'b1;
            state <= S_RESP;
          end else if (cur.kind != KindSet && !is_empty && is_match) begin
            if (cur.kind == KindGet) begin
              rsp.status <= ST_FOUND;
              rsp.found_value <= rd_val;
            end else begin
              rsp.status <= ST_REMOVED;
              if (entry_count != 11'd0) entry_count <= entry_count - 11'd1;
            end
            rsp_valid <= 1'b1;
            state <= S_RESP;
          end else if (last_probe) begin
            rsp.status <= (cur.kind == KindSet) ? ST_FULL : ST_NOT_FOUND;
            rsp_valid <= 1'b1;
            state <= S_RESP;
          end else begin
            slot <= slot + step_sq;
            step <= step + 1'b1;
            state <= S_READ;
          end
        end
        S_RESP: begin
          if (rsp_ready) begin
            rsp_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MQP_ASSERT_IMP(a_valid_in_resp, clk, rst, rsp_valid, state == S_RESP)
  `MQP_ASSERT_IMP(a_found_zero, clk, rst, rsp_valid && rsp.status != ST_FOUND,
    rsp.found_value == 32'd0)
  `MQP_ASSERT_NEXT(a_count_bound, clk, rst, state == S_CHECK,
    entry_count <= CountMax)

endmodule

@@ rtl/core/mqp_hash.sv @@
// ----------------------------------------------------------------------------
// mqp_hash
// Murmur-style 64-bit hash of a 128-bit key on one shared 32x32 multiplier.
// Each 64-bit multiply forms three partial products, then the result;
// seven multiplies per key.
// ----------------------------------------------------------------------------
module mqp_hash
  import mqp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  hash_req_t req,
  output hash_rsp_t rsp
);

  // 32x32 partial products, three per multiply, then the result
  typedef enum logic [3:0] {
    H_IDLE, H_M1, H_M2, H_M3, H_M4, H_M5, H_M6, H_M7, H_M8, H_DONE
  } hstate_t;

  hstate_t     state;
  logic [63:0] h;
  logic [63:0] key_high;
  logic [63:0] opnd;
  logic [63:0] prod;
  logic [1:0]  part;
  logic        done;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [63:0] pp;

  assign mul_a = (part == 2'd2) ? opnd[63:32] : opnd[31:0];
  assign mul_b = (part == 2'd1) ? HashMul[63:32] : HashMul[31:0];
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    case (part)
      2'd0: pp = mul_p;
      2'd1, 2'd2: pp = {mul_p[31:0], 32'd0};
      default: pp = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      part <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (state == H_IDLE) begin
        if (req.start) begin
          opnd <= req.key_low;
          key_high <= req.key_high;
          h <= HashSeed ^ (KeyBytes * HashMul);
          prod <= 64'd0;
          part <= 2'd0;
          state <= H_M1;
        end
      end else if (part != 2'd3) begin
        prod <= prod + pp;
        part <= part + 2'd1;
      end else begin
        part <= 2'd0;
        prod <= 64'd0;
        case (state)
          H_M1: begin opnd <= prod ^ (prod >> HashShift); state <= H_M2; end
          H_M2: begin opnd <= h ^ prod; state <= H_M3; end
          H_M3: begin h <= prod; opnd <= key_high; state <= H_M4; end
          H_M4: begin opnd <= prod ^ (prod >> HashShift); state <= H_M5; end
          H_M5: begin opnd <= h ^ prod; state <= H_M6; end
          H_M6: begin opnd <= prod ^ (prod >> HashShift); state <= H_M7; end
          H_M7: begin
            h <= prod ^ (prod >> HashShift);
            done <= 1'b1;
            state <= H_IDLE;
          end
          default: state <= H_IDLE;
        endcase
      end
    end
  end

  assign rsp.done = done;
  assign rsp.hash = h;

endmodule
